### rtl/pfs_pkg.sv
// Package: shared types and constants of the prime filter and sorter.
`timescale 1ns / 1ps

package pfs_pkg;

    localparam int unsigned OUT_WIDTH     = 15;
    localparam int unsigned FIRST_DIVISOR = 2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_TEST,
        ST_WAIT
    } top_state_t;

    typedef enum logic [1:0] {
        PT_IDLE,
        PT_CHECK,
        PT_DIV
    } pt_state_t;

    typedef enum logic [2:0] {
        SS_IDLE,
        SS_SHIFT,
        SS_PLACE,
        SS_AFTER,
        SS_EMIT
    } ss_state_t;

    typedef struct packed {
        logic done;
        logic is_prime;
    } pt_status_t;

    typedef struct packed {
        logic valid;
        logic insert;
        logic emit;
    } ss_cmd_t;

    typedef struct packed {
        logic busy;
    } ss_status_t;

endpackage

### rtl/pfs_prime_test.sv
// Trial-division primality tester with a bit-serial remainder unit.
`timescale 1ns / 1ps

module pfs_prime_test #(
    parameter int VALUE_WIDTH = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [VALUE_WIDTH-2:0] n,
    output pfs_pkg::pt_status_t    status
);

    localparam int PW = VALUE_WIDTH - 1;
    localparam int BW = $clog2(PW);

    pfs_pkg::pt_state_t state_reg, state_next;
    logic [PW-1:0] n_reg, n_next;
    logic [PW-1:0] d_reg, d_next;
    logic [PW:0]   sq_reg, sq_next;
    logic [PW-1:0] rem_reg, rem_next;
    logic [BW-1:0] bit_reg, bit_next;
    logic          done_reg, done_next;
    logic          prime_reg, prime_next;

    logic [PW:0]   shifted;
    logic [PW:0]   diff;
    logic          fits;
    logic [PW-1:0] rem_new;

    always_comb
    begin
        shifted = {rem_reg, n_reg[bit_reg]};
        diff    = shifted - {1'b0, d_reg};
        fits    = shifted >= {1'b0, d_reg};
        rem_new = fits ? diff[PW-1:0] : shifted[PW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pfs_pkg::PT_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg     <= n_next;
        d_reg     <= d_next;
        sq_reg    <= sq_next;
        rem_reg   <= rem_next;
        bit_reg   <= bit_next;
        prime_reg <= prime_next;
    end

    always_comb
    begin
        state_next = state_reg;
        n_next     = n_reg;
        d_next     = d_reg;
        sq_next    = sq_reg;
        rem_next   = rem_reg;
        bit_next   = bit_reg;
        done_next  = 1'b0;
        prime_next = prime_reg;
        unique case (state_reg)
            pfs_pkg::PT_IDLE:
            begin
                if (start)
                begin
                    n_next     = n;
                    d_next     = PW'(pfs_pkg::FIRST_DIVISOR);
                    sq_next    = (PW+1)'(pfs_pkg::FIRST_DIVISOR * pfs_pkg::FIRST_DIVISOR);
                    state_next = pfs_pkg::PT_CHECK;
                end
            end
            pfs_pkg::PT_CHECK:
            begin
                if (sq_reg > {1'b0, n_reg})
                begin
                    done_next  = 1'b1;
                    prime_next = 1'b1;
                    state_next = pfs_pkg::PT_IDLE;
                end
                else
                begin
                    rem_next   = '0;
                    bit_next   = BW'(PW - 1);
                    state_next = pfs_pkg::PT_DIV;
                end
            end
            pfs_pkg::PT_DIV:
            begin
                rem_next = rem_new;
                if (bit_reg == '0)
                begin
                    if (rem_new == '0)
                    begin
                        done_next  = 1'b1;
                        prime_next = 1'b0;
                        state_next = pfs_pkg::PT_IDLE;
                    end
                    else
                    begin
                        sq_next    = sq_reg + {d_reg, 1'b1};
                        d_next     = d_reg + PW'(1);
                        state_next = pfs_pkg::PT_CHECK;
                    end
                end
                else
                begin
                    bit_next = bit_reg - BW'(1);
                end
            end
            default:
            begin
                state_next = pfs_pkg::PT_IDLE;
            end
        endcase
    end

    assign status.done     = done_reg;
    assign status.is_prime = prime_reg;

`ifndef SYNTH
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("tester done held longer than one cycle");
`endif

endmodule

### rtl/pfs_store.sv
// Sorted prime store: memory, insertion by shifting, ordered readout.
`timescale 1ns / 1ps

module pfs_store #(
    parameter int STORE_DEPTH = 64,
    parameter int VALUE_WIDTH = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  pfs_pkg::ss_cmd_t               cmd,
    input  logic [VALUE_WIDTH-2:0]         cand,
    output pfs_pkg::ss_status_t            status,
    output logic [pfs_pkg::OUT_WIDTH-1:0]  prime_value,
    output logic                           present,
    output logic                           final_item,
    output logic                           overflow,
    output logic                           strobe
);

    localparam int PW = VALUE_WIDTH - 1;
    localparam int AW = $clog2(STORE_DEPTH);
    localparam int CW = $clog2(STORE_DEPTH + 1);

    logic [PW-1:0] mem [STORE_DEPTH];
    logic [PW-1:0] rd_data_reg;
    logic          we;
    logic [AW-1:0] wr_addr;
    logic [PW-1:0] wr_data;
    logic          re;
    logic [AW-1:0] rd_addr;

    pfs_pkg::ss_state_t state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic          dropped_reg, dropped_next;
    logic [AW-1:0] pos_reg, pos_next;
    logic [PW-1:0] p_reg, p_next;
    logic          emit_reg, emit_next;

    logic                          strobe_reg, strobe_next;
    logic [pfs_pkg::OUT_WIDTH-1:0] value_reg, value_next;
    logic                          present_reg, present_next;
    logic                          final_reg, final_next;
    logic                          ovf_reg, ovf_next;

    logic                          is_final;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (re)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= pfs_pkg::SS_IDLE;
            count_reg   <= '0;
            dropped_reg <= 1'b0;
            strobe_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            dropped_reg <= dropped_next;
            strobe_reg  <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg     <= pos_next;
        p_reg       <= p_next;
        emit_reg    <= emit_next;
        value_reg   <= value_next;
        present_reg <= present_next;
        final_reg   <= final_next;
        ovf_reg     <= ovf_next;
    end

    assign is_final = (CW'(pos_reg) + CW'(1)) == count_reg;

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        dropped_next = dropped_reg;
        pos_next     = pos_reg;
        p_next       = p_reg;
        emit_next    = emit_reg;
        strobe_next  = 1'b0;
        value_next   = value_reg;
        present_next = present_reg;
        final_next   = final_reg;
        ovf_next     = ovf_reg;
        we           = 1'b0;
        wr_addr      = pos_reg;
        wr_data      = p_reg;
        re           = 1'b0;
        rd_addr      = pos_reg;
        unique case (state_reg)
            pfs_pkg::SS_IDLE:
            begin
                if (cmd.valid)
                begin
                    p_next     = cand;
                    emit_next  = cmd.emit;
                    state_next = pfs_pkg::SS_AFTER;
                    if (cmd.insert)
                    begin
                        if (count_reg == CW'(STORE_DEPTH))
                        begin
                            dropped_next = 1'b1;
                        end
                        else if (count_reg == '0)
                        begin
                            we         = 1'b1;
                            wr_addr    = '0;
                            wr_data    = cand;
                            count_next = CW'(1);
                        end
                        else
                        begin
                            re         = 1'b1;
                            rd_addr    = AW'(count_reg - CW'(1));
                            pos_next   = AW'(count_reg);
                            state_next = pfs_pkg::SS_SHIFT;
                        end
                    end
                end
            end
            pfs_pkg::SS_SHIFT:
            begin
                we = 1'b1;
                if (rd_data_reg > p_reg)
                begin
                    wr_data  = rd_data_reg;
                    pos_next = pos_reg - AW'(1);
                    if (pos_reg == AW'(1))
                    begin
                        state_next = pfs_pkg::SS_PLACE;
                    end
                    else
                    begin
                        re      = 1'b1;
                        rd_addr = pos_reg - AW'(2);
                    end
                end
                else
                begin
                    count_next = count_reg + CW'(1);
                    state_next = pfs_pkg::SS_AFTER;
                end
            end
            pfs_pkg::SS_PLACE:
            begin
                we         = 1'b1;
                count_next = count_reg + CW'(1);
                state_next = pfs_pkg::SS_AFTER;
            end
            pfs_pkg::SS_AFTER:
            begin
                if (!emit_reg)
                begin
                    state_next = pfs_pkg::SS_IDLE;
                end
                else if (count_reg == '0)
                begin
                    strobe_next  = 1'b1;
                    value_next   = '0;
                    present_next = 1'b0;
                    final_next   = 1'b1;
                    ovf_next     = dropped_reg;
                    dropped_next = 1'b0;
                    state_next   = pfs_pkg::SS_IDLE;
                end
                else
                begin
                    re         = 1'b1;
                    rd_addr    = '0;
                    pos_next   = '0;
                    state_next = pfs_pkg::SS_EMIT;
                end
            end
            pfs_pkg::SS_EMIT:
            begin
                strobe_next  = 1'b1;
                value_next   = pfs_pkg::OUT_WIDTH'(rd_data_reg);
                present_next = 1'b1;
                final_next   = is_final;
                ovf_next     = dropped_reg;
                if (is_final)
                begin
                    count_next   = '0;
                    dropped_next = 1'b0;
                    state_next   = pfs_pkg::SS_IDLE;
                end
                else
                begin
                    re       = 1'b1;
                    rd_addr  = pos_reg + AW'(1);
                    pos_next = pos_reg + AW'(1);
                end
            end
            default:
            begin
                state_next = pfs_pkg::SS_IDLE;
            end
        endcase
    end

    assign status.busy = state_reg != pfs_pkg::SS_IDLE;
    assign strobe      = strobe_reg;
    assign prime_value = value_reg;
    assign present     = present_reg;
    assign final_item  = final_reg;
    assign overflow    = ovf_reg;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(STORE_DEPTH))
        else $error("kept count beyond store depth");

    a_empty_final: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe_reg && !present_reg) |-> (final_reg && value_reg == '0))
        else $error("empty word not marked final");

    a_final_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe_reg && final_reg) |-> (count_reg == '0 && !dropped_reg))
        else $error("store not cleared after final word");
`endif

endmodule

### rtl/prime_filter_sort_top.sv
// Top level: element intake, primality test sequencing and sorted store.
//
//   channel   direction  handshake            word
//   input     in         start & !busy        value, is_last
//   result    out        strobe, no stall     prime_value, present, final_item, overflow
//
// A value below two skips the primality test and is never inserted into the store.
// A candidate n is tried against divisors up to sqrt(n) in the one-bit-per-cycle
// remainder loop; insertion then shifts every stored prime larger than n up one place.
// On a last element the store is read out one word per cycle.
// Reset clears control state at once; no clearing pass. Results cannot be stalled.
`timescale 1ns / 1ps

module prime_filter_sort_top #(
    parameter int STORE_DEPTH = 64,
    parameter int VALUE_WIDTH = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [VALUE_WIDTH-1:0] value,
    input  logic                          is_last,
    output logic [pfs_pkg::OUT_WIDTH-1:0] prime_value,
    output logic                          present,
    output logic                          final_item,
    output logic                          overflow,
    output logic                          strobe
);

    localparam int PW = VALUE_WIDTH - 1;

    pfs_pkg::top_state_t state_reg, state_next;
    logic          last_reg, last_next;
    logic [PW-1:0] cand_reg, cand_next;

    logic                accept;
    logic                candidate;
    logic                tst_start;
    pfs_pkg::pt_status_t tst_status;
    pfs_pkg::ss_cmd_t    st_cmd;
    pfs_pkg::ss_status_t st_status;

    assign accept    = start && (state_reg == pfs_pkg::ST_IDLE);
    assign candidate = !value[VALUE_WIDTH-1] && (value[PW-1:0] > PW'(1));
    assign tst_start = accept && candidate;
    assign busy      = state_reg != pfs_pkg::ST_IDLE;

    pfs_prime_test #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_test (
        .clk   (clk),
        .rst_n (rst_n),
        .start (tst_start),
        .n     (value[PW-1:0]),
        .status(tst_status)
    );

    pfs_store #(
        .STORE_DEPTH(STORE_DEPTH),
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_store (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (st_cmd),
        .cand       (cand_reg),
        .status     (st_status),
        .prime_value(prime_value),
        .present    (present),
        .final_item (final_item),
        .overflow   (overflow),
        .strobe     (strobe)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pfs_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        last_reg <= last_next;
        cand_reg <= cand_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        last_next     = last_reg;
        cand_next     = cand_reg;
        st_cmd.valid  = 1'b0;
        st_cmd.insert = 1'b0;
        st_cmd.emit   = 1'b0;
        unique case (state_reg)
            pfs_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    last_next = is_last;
                    cand_next = value[PW-1:0];
                    if (candidate)
                    begin
                        state_next = pfs_pkg::ST_TEST;
                    end
                    else
                    begin
                        st_cmd.valid = 1'b1;
                        st_cmd.emit  = is_last;
                        state_next   = pfs_pkg::ST_WAIT;
                    end
                end
            end
            pfs_pkg::ST_TEST:
            begin
                if (tst_status.done)
                begin
                    st_cmd.valid  = 1'b1;
                    st_cmd.insert = tst_status.is_prime;
                    st_cmd.emit   = last_reg;
                    state_next    = pfs_pkg::ST_WAIT;
                end
            end
            pfs_pkg::ST_WAIT:
            begin
                if (!st_status.busy)
                begin
                    state_next = pfs_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pfs_pkg::ST_IDLE;
            end
        endcase
    end

`ifndef SYNTH
    a_idle_store_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !busy |-> !st_status.busy)
        else $error("store active while block idle");

    a_cmd_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        st_cmd.valid |-> !st_status.busy)
        else $error("store command issued while store busy");
`endif

endmodule

### tb/sv/tb_prime_filter_sort_top.sv
// Testbench: drives element runs into the prime filter and sorter, checks sorted primes.
`timescale 1ns / 1ps

module tb_prime_filter_sort_top;

    localparam int STORE_DEPTH   = 64;
    localparam int VALUE_WIDTH   = 16;
    localparam int RANDOM_ITEMS  = 190;
    localparam int DRAIN_CYCLES  = 200;
    localparam int CYCLE_LIMIT   = 3_000_000;
    localparam int DIRECTED_LEN  = 23;

    typedef struct packed {
        logic [pfs_pkg::OUT_WIDTH-1:0] prime_value;
        logic                          present;
        logic                          final_item;
        logic                          overflow;
    } prime_word_t;

    typedef struct packed {
        logic [VALUE_WIDTH-1:0] value;
        logic                   last;
        logic                   typed;
        prime_word_t            word;
    } dir_row_t;

    localparam prime_word_t NO_PRIME = '{15'd0, 1'b0, 1'b1, 1'b0};
    localparam prime_word_t NONE_ROW = '{15'd0, 1'b0, 1'b0, 1'b0};

    localparam dir_row_t DIRECTED_ROWS [DIRECTED_LEN] = '{
        '{16'h8000, 1'b1, 1'b1, NO_PRIME},
        '{16'h7FFF, 1'b1, 1'b1, NO_PRIME},
        '{16'h0000, 1'b1, 1'b1, NO_PRIME},
        '{16'h0001, 1'b1, 1'b1, NO_PRIME},
        '{16'hFFFF, 1'b0, 1'b0, NONE_ROW},
        '{16'h0002, 1'b1, 1'b1, '{15'd2, 1'b1, 1'b1, 1'b0}},
        '{16'h7FED, 1'b1, 1'b1, '{15'd32749, 1'b1, 1'b1, 1'b0}},
        '{16'hFFFE, 1'b1, 1'b1, NO_PRIME},
        '{16'h0007, 1'b0, 1'b0, NONE_ROW},
        '{16'h0005, 1'b0, 1'b0, NONE_ROW},
        '{16'h0007, 1'b0, 1'b0, NONE_ROW},
        '{16'hFFF9, 1'b0, 1'b0, NONE_ROW},
        '{16'h0004, 1'b0, 1'b0, NONE_ROW},
        '{16'h0002, 1'b0, 1'b0, NONE_ROW},
        '{16'h5555, 1'b0, 1'b0, NONE_ROW},
        '{16'hAAAA, 1'b0, 1'b0, NONE_ROW},
        '{16'h7FED, 1'b0, 1'b0, NONE_ROW},
        '{16'h0003, 1'b1, 1'b0, NONE_ROW},
        '{16'h0001, 1'b0, 1'b0, NONE_ROW},
        '{16'h0000, 1'b0, 1'b0, NONE_ROW},
        '{16'h0019, 1'b1, 1'b0, NONE_ROW},
        '{16'h000D, 1'b0, 1'b0, NONE_ROW},
        '{16'h000D, 1'b1, 1'b0, NONE_ROW}
    };

    logic                                 clk;
    logic                                 rst_n   = 1'b0;
    logic                                 start   = 1'b0;
    logic signed [VALUE_WIDTH-1:0]        value   = '0;
    logic                                 is_last = 1'b0;
    logic                                 busy;
    logic        [pfs_pkg::OUT_WIDTH-1:0] prime_value;
    logic                                 present;
    logic                                 final_item;
    logic                                 overflow;
    logic                                 strobe;

    prime_word_t expected_words[$];
    int          kept_primes[$];
    bit          primes_dropped;
    bit          steady;
    int          mismatches;
    int          cycle_count;

    prime_filter_sort_top #(
        .STORE_DEPTH (STORE_DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .value       (value),
        .is_last     (is_last),
        .prime_value (prime_value),
        .present     (present),
        .final_item  (final_item),
        .overflow    (overflow),
        .strobe      (strobe)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_prime_filter_sort_top NOT OK");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("%0t mismatch: %s", $time, msg);
        mismatches++;
    endtask

    function automatic bit prime_check(input int v);
        if (v < 2)
            return 1'b0;
        for (int d = 2; d * d <= v; d++)
        begin
            if (v % d == 0)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic logic signed [VALUE_WIDTH-1:0] random_prime(input int hi);
        int v;
        do
            v = $urandom_range(2, hi);
        while (!prime_check(v));
        return VALUE_WIDTH'(v);
    endfunction

    function automatic logic signed [VALUE_WIDTH-1:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30)
            return random_prime(255);
        if (r < 45)
            return random_prime(32767);
        if (r < 55)
            return VALUE_WIDTH'($urandom_range(0, 3));
        if (r < 70)
            return VALUE_WIDTH'(0 - $urandom_range(1, 32768));
        return VALUE_WIDTH'($urandom);
    endfunction

    function automatic int idle_gap();
        int g;
        g = 0;
        if (steady)
            return 0;
        while ($urandom_range(0, 99) < 25)
            g++;
        return g;
    endfunction

    // Update the sorted prime store and queue the words a last element releases.
    function automatic void sort_primes(input logic signed [VALUE_WIDTH-1:0] v,
                                        input logic last, input bit typed,
                                        input prime_word_t typed_word);
        int          pos;
        prime_word_t w;
        if (prime_check(int'(v)))
        begin
            if (kept_primes.size() < STORE_DEPTH)
            begin
                pos = 0;
                while (pos < kept_primes.size() && kept_primes[pos] <= int'(v))
                    pos++;
                kept_primes.insert(pos, int'(v));
            end
            else
                primes_dropped = 1'b1;
        end
        if (last)
        begin
            if (typed)
                expected_words.push_back(typed_word);
            else if (kept_primes.size() == 0)
            begin
                w = NO_PRIME;
                w.overflow = primes_dropped;
                expected_words.push_back(w);
            end
            else
            begin
                foreach (kept_primes[i])
                begin
                    w.prime_value = pfs_pkg::OUT_WIDTH'(kept_primes[i]);
                    w.present     = 1'b1;
                    w.final_item  = (i == kept_primes.size() - 1);
                    w.overflow    = primes_dropped;
                    expected_words.push_back(w);
                end
            end
            kept_primes.delete();
            primes_dropped = 1'b0;
        end
    endfunction

    task automatic send_word(input logic signed [VALUE_WIDTH-1:0] v, input logic last,
                             input bit typed, input prime_word_t typed_word);
        int gap;
        gap = idle_gap();
        if (gap > 0)
        begin
            start   <= 1'b0;
            value   <= VALUE_WIDTH'($urandom);
            is_last <= 1'($urandom);
            repeat (gap) @(posedge clk);
        end
        start   <= 1'b1;
        value   <= v;
        is_last <= last;
        do
            @(posedge clk);
        while (busy);
        sort_primes(v, last, typed, typed_word);
    endtask

    task automatic hold_until_drained();
        start <= 1'b0;
        do
            @(posedge clk);
        while (expected_words.size() != 0);
    endtask

    always @(posedge clk)
    begin : check_words
        prime_word_t want;
        if (rst_n && strobe)
        begin
            if (expected_words.size() == 0)
                report_mismatch($sformatf("unexpected word prime_value=%0d", prime_value));
            else
            begin
                want = expected_words.pop_front();
                if (prime_value !== want.prime_value)
                    report_mismatch($sformatf("prime_value %0d, want %0d",
                                              prime_value, want.prime_value));
                if (present !== want.present)
                    report_mismatch($sformatf("present %b, want %b", present, want.present));
                if (final_item !== want.final_item)
                    report_mismatch($sformatf("final_item %b, want %b",
                                              final_item, want.final_item));
                if (overflow !== want.overflow)
                    report_mismatch($sformatf("overflow %b, want %b",
                                              overflow, want.overflow));
            end
        end
    end

    initial
    begin
        int random_items;
        int full_runs;
        int run_len;
        random_items = 0;
        full_runs    = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED_ROWS[n])
            send_word(DIRECTED_ROWS[n].value, DIRECTED_ROWS[n].last,
                      DIRECTED_ROWS[n].typed, DIRECTED_ROWS[n].word);
        hold_until_drained();

        while (random_items < RANDOM_ITEMS)
        begin
            if ((full_runs == 0 && random_items >= 30) ||
                (full_runs == 1 && random_items >= 110))
            begin
                // fill the store exactly, then past its depth
                run_len = STORE_DEPTH + (full_runs == 0 ? 0 : $urandom_range(1, 5));
                for (int k = 0; k < run_len; k++)
                    send_word(random_prime(251), 1'b0, 1'b0, NONE_ROW);
                if (full_runs == 0)
                    send_word(VALUE_WIDTH'(2 * $urandom_range(2, 100)), 1'b1, 1'b0, NONE_ROW);
                else
                    send_word(random_prime(32767), 1'b1, 1'b0, NONE_ROW);
                run_len++;
                full_runs++;
            end
            else
            begin
                run_len = $urandom_range(1, 12);
                for (int k = 0; k < run_len; k++)
                    send_word(pick_value(), k == run_len - 1, 1'b0, NONE_ROW);
            end
            random_items += run_len;
            steady = (random_items >= 150 && random_items < 200);
            if ($urandom_range(0, 3) == 0)
                hold_until_drained();
        end

        hold_until_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("tb_prime_filter_sort_top OK");
        else
            $display("tb_prime_filter_sort_top NOT OK");
        $finish;
    end

endmodule

### filelist.f
rtl/pfs_pkg.sv
rtl/pfs_prime_test.sv
rtl/pfs_store.sv
rtl/prime_filter_sort_top.sv
tb/sv/tb_prime_filter_sort_top.sv
